>>> hw/rtl/box_coordinate_moving_average_top_macros.svh
`ifndef BOX_COORDINATE_MOVING_AVERAGE_TOP_MACROS_SVH
`define BOX_COORDINATE_MOVING_AVERAGE_TOP_MACROS_SVH

// checked only out of reset
`define BCMA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bcma assertion failed");

// checked at every edge, reset included
`define BCMA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("bcma assertion failed");

`endif

>>> hw/rtl/bcma_pkg.sv
`default_nettype none

package bcma_pkg;

  localparam int WINDOW     = 30;
  localparam int COORD_BITS = 14;
  localparam int LANES      = 4;

  localparam int IN_W     = 10;
  localparam int FACTOR_W = 4;
  localparam int OUT_W    = 14;
  localparam int SCALE_W  = IN_W + FACTOR_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(7);

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int SUM_W     = COORD_BITS + $clog2(WINDOW);
  localparam int FILL_W    = $clog2(WINDOW + 1);

  // floor(x / WINDOW) = (x * RECIP_M) >> DIV_SHIFT, exact for x below 2^SUM_W
  localparam int    DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int    MUL_W     = SUM_W + 1;
  localparam int    PROD_W    = SUM_W + MUL_W;
  localparam longint RECIP_L  = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MUL_W-1:0] RECIP_M = MUL_W'(RECIP_L);

  // lane order inside a box
  localparam int LANE_LEFT   = 0;
  localparam int LANE_TOP    = 1;
  localparam int LANE_RIGHT  = 2;
  localparam int LANE_BOTTOM = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [LANES-1:0]    box_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef sum_t [LANES-1:0]      sums_t;
  typedef logic [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic  full;
    sums_t sums;
  } win_stat_t;

  function automatic coord_t scale_coord(logic [IN_W-1:0] v, logic [FACTOR_W-1:0] f);
    logic [SCALE_W-1:0] p;
    p = v * f;
    if (int'(p) > COORD_MAX) begin
      return COORD_BITS'(COORD_MAX);
    end
    return COORD_BITS'(p);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcma_cell.sv
`default_nettype none

module bcma_cell import bcma_pkg::*; (
  input  wire  clk_i,
  input  wire  en_i,
  input  box_t box_i,
  output box_t box_o
);

  box_t box_q;

  // one stored box, shifts to the neighbor on each push
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q <= box_i;
    end
  end

  assign box_o = box_q;

endmodule

`default_nettype wire

>>> hw/rtl/bcma_window.sv
`default_nettype none

module bcma_window import bcma_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push_i,
  input  box_t      fresh_i,
  output win_stat_t stat_o
);

  box_t chain [WINDOW];

  logic [FILL_W-1:0] fill_q, fill_d;
  sums_t             sums_q, sums_d;
  logic              full;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      bcma_cell u_cell (
        .clk_i (clk_i),
        .en_i  (push_i),
        .box_i (fresh_i),
        .box_o (chain[i])
      );
    end else begin : g_link
      bcma_cell u_cell (
        .clk_i (clk_i),
        .en_i  (push_i),
        .box_i (chain[i-1]),
        .box_o (chain[i])
      );
    end
  end

  assign full = (fill_q == FILL_W'(WINDOW));

  always_comb begin
    fill_d = fill_q;
    sums_d = sums_q;
    if (push_i) begin
      for (int k = 0; k < LANES; k++) begin
        if (full) begin
          // last cell holds the oldest box once the window is full
          sums_d[k] = sums_q[k] - SUM_W'(chain[WINDOW-1][k]) + SUM_W'(fresh_i[k]);
        end else begin
          sums_d[k] = sums_q[k] + SUM_W'(fresh_i[k]);
        end
      end
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sums_q <= '0;
    end else begin
      fill_q <= fill_d;
      sums_q <= sums_d;
    end
  end

  assign stat_o.full = full;
  assign stat_o.sums = sums_q;

endmodule

`default_nettype wire

>>> hw/rtl/box_coordinate_moving_average_top.sv
// channel   direction  handshake                    payload
// in        sink       in_valid_i / in_ready_o      top_left_x_i .. bottom_right_y_i
// out       source     out_valid_o / out_ready_i    average_valid_o, avg_*_o
// cfg       sink       cfg_valid_i / cfg_ready_o    cfg_data_i (upscale factor)
//
// one box per cycle sustained while out_ready_i is high; each beat passes every stage register
// stages: upscale, window update and sum snapshot, reciprocal multiply
// reset clears the fill count, running sums, pipeline valids; factor returns to 7
// a stalled output holds each stage that is full; empty stages still take beats
// cfg_ready_o is always high, the factor takes effect on the next accepted beat
`default_nettype none

module box_coordinate_moving_average_top import bcma_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,

  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [FACTOR_W-1:0] cfg_data_i,

  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [IN_W-1:0]     top_left_x_i,
  input  wire  [IN_W-1:0]     top_left_y_i,
  input  wire  [IN_W-1:0]     bottom_right_x_i,
  input  wire  [IN_W-1:0]     bottom_right_y_i,

  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                average_valid_o,
  output logic [OUT_W-1:0]    avg_left_x_o,
  output logic [OUT_W-1:0]    avg_top_y_o,
  output logic [OUT_W-1:0]    avg_right_x_o,
  output logic [OUT_W-1:0]    avg_bottom_y_o
);

  // upscale factor register
  logic [FACTOR_W-1:0] factor_q;

  // stage 1: upscaled box
  logic v1_q;
  box_t fresh_q, fresh_d;

  // stage 2: sums before this beat's update, zero while filling
  logic  v2_q, full2_q;
  sums_t snap_q, snap_d;

  // stage 3: sums times reciprocal, the output register
  logic  v3_q, full3_q;
  prod_t prod_q [LANES];

  logic ready1, ready2, ready3;
  logic push;

  win_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_valid_i) begin
      factor_q <= cfg_data_i;
    end
  end

  // each stage moves when it is empty or the next one moves
  assign ready3     = !v3_q || out_ready_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;
  assign push       = v1_q && ready2;

  // multiply by the factor and clip at the coordinate range top
  always_comb begin
    fresh_d              = '0;
    fresh_d[LANE_LEFT]   = scale_coord(top_left_x_i, factor_q);
    fresh_d[LANE_TOP]    = scale_coord(top_left_y_i, factor_q);
    fresh_d[LANE_RIGHT]  = scale_coord(bottom_right_x_i, factor_q);
    fresh_d[LANE_BOTTOM] = scale_coord(bottom_right_y_i, factor_q);
  end

  // delay line of cells plus running sums and fill count
  bcma_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .fresh_i (fresh_q),
    .stat_o  (stat)
  );

  // a filling window yields an empty box, so the sums are masked to zero
  assign snap_d = stat.full ? stat.sums : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      full2_q <= 1'b0;
      full3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          full2_q <= stat.full;
        end
      end
      if (ready3) begin
        v3_q <= v2_q;
        if (v2_q) begin
          full3_q <= full2_q;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      fresh_q <= fresh_d;
    end
    if (push) begin
      snap_q <= snap_d;
    end
    if (ready3 && v2_q) begin
      for (int k = 0; k < LANES; k++) begin
        // floor division by the window length through an exact reciprocal
        prod_q[k] <= snap_q[k] * RECIP_M;
      end
    end
  end

  assign out_valid_o     = v3_q;
  assign average_valid_o = full3_q;
  assign avg_left_x_o    = OUT_W'(prod_q[LANE_LEFT][DIV_SHIFT +: COORD_BITS]);
  assign avg_top_y_o     = OUT_W'(prod_q[LANE_TOP][DIV_SHIFT +: COORD_BITS]);
  assign avg_right_x_o   = OUT_W'(prod_q[LANE_RIGHT][DIV_SHIFT +: COORD_BITS]);
  assign avg_bottom_y_o  = OUT_W'(prod_q[LANE_BOTTOM][DIV_SHIFT +: COORD_BITS]);

endmodule

`default_nettype wire

>>> hw/rtl/bcma_checker.sv
`default_nettype none
`include "box_coordinate_moving_average_top_macros.svh"

module bcma_checker import bcma_pkg::*; (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                cfg_valid_i,
  input wire                cfg_ready_o,
  input wire [FACTOR_W-1:0] cfg_data_i,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input wire [IN_W-1:0]     top_left_x_i,
  input wire [IN_W-1:0]     top_left_y_i,
  input wire [IN_W-1:0]     bottom_right_x_i,
  input wire [IN_W-1:0]     bottom_right_y_i,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input wire                average_valid_o,
  input wire [OUT_W-1:0]    avg_left_x_o,
  input wire [OUT_W-1:0]    avg_top_y_o,
  input wire [OUT_W-1:0]    avg_right_x_o,
  input wire [OUT_W-1:0]    avg_bottom_y_o
);

  // nothing leaves the block while reset is held
  `BCMA_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o)

  // an empty box carries zero averages
  `BCMA_ASSERT(a_empty_box_zero, (out_valid_o && !average_valid_o) |-> (avg_left_x_o == '0 && avg_top_y_o == '0 && avg_right_x_o == '0 && avg_bottom_y_o == '0))

  // a taken output frees the whole pipeline for a new beat
  `BCMA_ASSERT(a_ready_passes, out_ready_i |-> in_ready_o)

  // a stalled result holds
  `BCMA_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(average_valid_o) && $stable(avg_left_x_o) && $stable(avg_bottom_y_o)))

endmodule

bind box_coordinate_moving_average_top bcma_checker u_checker (.*);

`default_nettype wire
